>>> rtl/iar_pkg.sv
// ----------------------------------------------------------------------------
// iar_pkg
// Shared types, codes and helpers for the identifier allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package iar_pkg;

    localparam int unsigned ID_W         = 8;
    localparam int unsigned ID_LIMIT     = 1 << ID_W;
    localparam int unsigned ID_COUNT_DEF = 256;
    localparam int unsigned GRP_BW       = 4;
    localparam int unsigned GRP_W        = 1 << GRP_BW;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_CLAIM   = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_INVALID   = 2'd2
    } t_status;

    typedef logic [GRP_W-1:0] t_word;

    // lowest set bit of a group word
    function automatic logic [GRP_BW-1:0] low_bit(input t_word w);
        logic [GRP_BW-1:0] r;
        r = '0;
        for (int i = GRP_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                r = GRP_BW'(i);
            end
        end
        return r;
    endfunction

    // highest set bit of a group word
    function automatic logic [GRP_BW-1:0] high_bit(input t_word w);
        logic [GRP_BW-1:0] r;
        r = '0;
        for (int i = 0; i < GRP_W; i++) begin
            if (w[i]) begin
                r = GRP_BW'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/id_allocator_reuse_lowest.sv
// ----------------------------------------------------------------------------
// id_allocator_reuse_lowest
// Identifier allocator that reuses the lowest released identifier first.
//
//   channel   handshake              payload
//   request   start / busy           i_action, i_request_id
//   result    o_done (one cycle)     o_granted_id, o_status
//
// One request per cycle while busy is low; the result strobe follows the request
// through the input register, then the result register.
// The maps are kept in flip-flops, grouped in words of sixteen with a
// per-word occupancy bit; each request does a group search then a word search.
// busy is high only during reset and the cycle after it.
// The receiver cannot stall: every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module id_allocator_reuse_lowest
    import iar_pkg::*;
#(
    parameter int unsigned ID_COUNT = ID_COUNT_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic [1:0]      i_action,
    input  wire logic [ID_W-1:0] i_request_id,
    output logic                 o_done,
    output logic [ID_W-1:0]      o_granted_id,
    output logic [1:0]           o_status
);

    localparam int unsigned ID_SPAN = (ID_COUNT < ID_LIMIT) ? ID_COUNT : ID_LIMIT;
    localparam int unsigned NGRP    = (ID_SPAN + GRP_W - 1) / GRP_W;
    localparam int unsigned GI_W    = (NGRP > 1) ? $clog2(NGRP) : 1;

    logic            r_rdy;
    logic            r_vld;
    logic [1:0]      r_act;
    logic [ID_W-1:0] r_id;
    logic            r_done;
    logic [ID_W-1:0] r_gid;
    t_status         r_st;

    t_word           r_amap [NGRP];
    t_word           r_fmap [NGRP];
    logic [NGRP-1:0] r_aany;
    logic [NGRP-1:0] r_fany;

    logic [GI_W-1:0]   lg;
    logic [GI_W-1:0]   hg;
    logic [GRP_BW-1:0] lb;
    logic [GRP_BW-1:0] hb;
    logic              f_hit;
    logic              a_hit;
    logic [ID_W:0]     next_id;
    logic [ID_W-1:0]   tgt;
    logic              wr;
    logic              set_a;
    t_status           st;
    logic [GI_W-1:0]   tg;
    logic [GRP_BW-1:0] tb;
    t_word             n_aword;
    t_word             n_fword;
    logic              take;

    assign take = start & r_rdy;

    // group search
    always_comb begin
        lg = '0;
        hg = '0;
        for (int i = NGRP - 1; i >= 0; i--) begin
            if (r_fany[i]) begin
                lg = GI_W'(i);
            end
        end
        for (int i = 0; i < NGRP; i++) begin
            if (r_aany[i]) begin
                hg = GI_W'(i);
            end
        end
    end

    assign f_hit   = |r_fany;
    assign a_hit   = |r_aany;
    assign lb      = low_bit(r_fmap[lg]);
    assign hb      = high_bit(r_amap[hg]);
    assign next_id = a_hit ? ((ID_W + 1)'({hg, hb}) + (ID_W + 1)'(1)) : (ID_W + 1)'(1);

    always_comb begin
        tgt   = '0;
        wr    = 1'b0;
        set_a = 1'b1;
        st    = ST_INVALID;
        unique case (r_act)
            ACT_ALLOC: begin
                if (f_hit) begin
                    tgt = ID_W'({lg, lb});
                    wr  = 1'b1;
                    st  = ST_OK;
                end else if (next_id >= (ID_W + 1)'(ID_SPAN)) begin
                    st = ST_EXHAUSTED;
                end else begin
                    tgt = next_id[ID_W-1:0];
                    wr  = 1'b1;
                    st  = ST_OK;
                end
            end
            ACT_CLAIM, ACT_RELEASE: begin
                if (r_id != '0 && {1'b0, r_id} < (ID_W + 1)'(ID_SPAN)) begin
                    tgt   = r_id;
                    wr    = 1'b1;
                    set_a = (r_act == ACT_CLAIM);
                    st    = ST_OK;
                end
            end
            default: begin
                st = ST_INVALID;
            end
        endcase
    end

    assign tg = GI_W'(tgt[ID_W-1:GRP_BW]);
    assign tb = tgt[GRP_BW-1:0];

    always_comb begin
        n_aword     = r_amap[tg];
        n_fword     = r_fmap[tg];
        n_aword[tb] = set_a;
        n_fword[tb] = ~set_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy  <= 1'b0;
            r_vld  <= 1'b0;
            r_done <= 1'b0;
            r_aany <= '0;
            r_fany <= '0;
            for (int i = 0; i < NGRP; i++) begin
                r_amap[i] <= '0;
                r_fmap[i] <= '0;
            end
        end else begin
            r_rdy  <= 1'b1;
            r_vld  <= take;
            r_done <= r_vld;
            if (r_vld && wr) begin
                r_amap[tg] <= n_aword;
                r_fmap[tg] <= n_fword;
                r_aany[tg] <= |n_aword;
                r_fany[tg] <= |n_fword;
            end
        end
    end

    // payload: hold inputs on transfer, capture result per item
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_act <= i_action;
            r_id  <= i_request_id;
        end
        if (r_vld) begin
            r_gid <= (st == ST_OK) ? tgt : '0;
            r_st  <= st;
        end
    end

    assign busy         = ~r_rdy;
    assign o_done       = r_done;
    assign o_granted_id = r_gid;
    assign o_status     = r_st;

endmodule

`default_nettype wire

>>> rtl/iar_chk.sv
// ----------------------------------------------------------------------------
// iar_chk
// Port-level checks for the identifier allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module iar_chk
    import iar_pkg::*;
(
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            start,
    input wire logic            busy,
    input wire logic [1:0]      i_action,
    input wire logic            o_done,
    input wire logic [ID_W-1:0] o_granted_id,
    input wire logic [1:0]      o_status
);

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n, 2) |-> (o_done == $past(start && !busy, 2)))
        else $error("result strobe does not match accepted request");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_status == ST_OK) == (o_granted_id != '0)))
        else $error("granted identifier inconsistent with status");

    a_ready: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> !busy)
        else $error("busy after reset");

    a_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(o_done) && o_status == ST_OK && $past(o_status) == ST_OK
         && $past(i_action, 2) == ACT_ALLOC && $past(i_action, 3) == ACT_ALLOC)
        |-> (o_granted_id != $past(o_granted_id)))
        else $error("same identifier allocated twice in a row");

endmodule

bind id_allocator_reuse_lowest iar_chk u_iar_chk (.*);

`default_nettype wire

>>> tb/id_alloc_checker.sv
// ----------------------------------------------------------------------------
// id_alloc_checker
// Watches the request and result channels of the identifier allocator, keeps
// its own assigned and freed maps, predicts the grant for every accepted
// request and compares each result strobe with the oldest pending grant.
// ----------------------------------------------------------------------------
`default_nettype none

module id_alloc_checker
    import iar_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic            i_busy,
    input  wire logic [1:0]      i_action,
    input  wire logic [ID_W-1:0] i_request_id,
    input  wire logic            i_done,
    input  wire logic [ID_W-1:0] i_granted_id,
    input  wire logic [1:0]      i_status,
    output int                   o_failures,
    output int                   o_outstanding
);

    localparam int unsigned SPAN = (ID_COUNT_DEF < ID_LIMIT) ? ID_COUNT_DEF : ID_LIMIT;
    localparam int unsigned FIFO_DEPTH = 8;

    typedef struct packed {
        logic [ID_W-1:0] id;
        t_status         st;
    } t_grant;

    logic [ID_LIMIT-1:0] model_used;
    logic [ID_LIMIT-1:0] model_released;
    t_grant              grant_fifo [FIFO_DEPTH];
    logic [2:0]          rd_ptr;
    logic [2:0]          wr_ptr;
    int                  fill;
    int                  failures;

    function automatic t_grant grant_for_request(input logic [1:0] act,
                                                 input logic [ID_W-1:0] id);
        t_grant      g;
        bit          found;
        int unsigned next_id;
        g.id    = '0;
        g.st    = ST_INVALID;
        found   = 1'b0;
        next_id = 1;
        if (act == ACT_ALLOC) begin
            for (int unsigned i = 1; i < SPAN; i++) begin
                if (!found && model_released[i]) begin
                    found             = 1'b1;
                    model_released[i] = 1'b0;
                    model_used[i]     = 1'b1;
                    g.id              = ID_W'(i);
                    g.st              = ST_OK;
                end
            end
            if (!found) begin
                for (int unsigned i = 1; i < SPAN; i++) begin
                    if (model_used[i]) begin
                        next_id = i + 1;
                    end
                end
                if (next_id >= SPAN) begin
                    g.st = ST_EXHAUSTED;
                end else begin
                    model_used[next_id] = 1'b1;
                    g.id                = ID_W'(next_id);
                    g.st                = ST_OK;
                end
            end
        end else if ((act == ACT_CLAIM || act == ACT_RELEASE)
                     && id != '0 && int'(id) < SPAN) begin
            model_used[id]     = (act == ACT_CLAIM);
            model_released[id] = (act == ACT_RELEASE);
            g.id               = id;
            g.st               = ST_OK;
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            model_used     = '0;
            model_released = '0;
            rd_ptr         = '0;
            wr_ptr         = '0;
            fill           = 0;
            failures       = 0;
        end else begin
            if (i_done) begin
                if (fill == 0) begin
                    $error("result transfer with no grant pending: granted_id %0d status %0d",
                           i_granted_id, i_status);
                    failures++;
                end else begin
                    want   = grant_fifo[rd_ptr];
                    rd_ptr = rd_ptr + 3'd1;
                    fill--;
                    if (i_granted_id !== want.id) begin
                        $error("granted_id: expected %0d, actual %0d", want.id, i_granted_id);
                        failures++;
                    end
                    if (i_status !== want.st) begin
                        $error("status: expected %0d, actual %0d", want.st, i_status);
                        failures++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (fill == int'(FIFO_DEPTH)) begin
                    $error("request transfer with too many grants pending");
                    failures++;
                end else begin
                    grant_fifo[wr_ptr] = grant_for_request(i_action, i_request_id);
                    wr_ptr             = wr_ptr + 3'd1;
                    fill++;
                end
            end
        end
        o_failures    <= failures;
        o_outstanding <= fill;
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the identifier allocator with a directed run over its corner cases
// (gaps, exhaustion, reuse of released ids, id zero, unused action) followed
// by random phases of allocate, claim and release with random idle cycles.
// Checking is done by id_alloc_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import iar_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         PHASES     = 12;
    localparam int         PHASE_LEN  = 96;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    logic [1:0]      i_action;
    logic [ID_W-1:0] i_request_id;
    logic            o_done;
    logic [ID_W-1:0] o_granted_id;
    logic [1:0]      o_status;
    int              failures;
    int              outstanding;

    id_allocator_reuse_lowest dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_request_id (i_request_id),
        .o_done       (o_done),
        .o_granted_id (o_granted_id),
        .o_status     (o_status)
    );

    id_alloc_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_action      (i_action),
        .i_request_id  (i_request_id),
        .i_done        (o_done),
        .i_granted_id  (o_granted_id),
        .i_status      (o_status),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_request(input logic [1:0] act, input logic [ID_W-1:0] id,
                                input int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_action     <= act;
        i_request_id <= id;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_directed(input logic [1:0] act, input logic [ID_W-1:0] id);
        send_request(act, id, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14));
    endtask

    task automatic drain_grants;
        start <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    function automatic logic [ID_W-1:0] pick_id;
        case ($urandom_range(0, 3))
            0:       return ID_W'($urandom_range(0, 255));
            1:       return ID_W'($urandom_range(0, 20));
            2:       return ID_W'($urandom_range(235, 255));
            default: return ID_W'($urandom_range(1, 63));
        endcase
    endfunction

    initial begin
        int unsigned mode;
        int unsigned roll;
        int unsigned alloc_lim;
        int unsigned claim_lim;
        bit          no_idle;
        logic [1:0]  act;

        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_action     <= ACT_ALLOC;
        i_request_id <= '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_directed(ACT_CLAIM, 8'd5);
        send_directed(ACT_ALLOC, 8'd0);
        send_directed(ACT_ALLOC, 8'd255);
        send_directed(ACT_CLAIM, 8'd0);
        send_directed(ACT_RELEASE, 8'd0);
        send_directed(ACT_CLAIM, 8'd255);
        send_directed(ACT_ALLOC, 8'd0);
        send_directed(ACT_RELEASE, 8'd255);
        send_directed(ACT_ALLOC, 8'd0);
        send_directed(ACT_ALLOC, 8'd0);
        send_directed(ACT_RELEASE, 8'd6);
        send_directed(ACT_RELEASE, 8'd100);
        send_directed(ACT_ALLOC, 8'd0);
        send_directed(ACT_ALLOC, 8'd0);
        send_directed(ACT_CLAIM, 8'd5);
        send_directed(ACT_RELEASE, 8'd85);
        send_directed(ACT_CLAIM, 8'd85);
        send_directed(ACT_CLAIM, 8'd170);
        send_directed(ACT_UNUSED, 8'd255);
        send_directed(ACT_UNUSED, 8'd0);
        send_directed(ACT_RELEASE, 8'd255);
        send_directed(ACT_RELEASE, 8'd170);
        send_directed(ACT_ALLOC, 8'd0);
        send_directed(ACT_ALLOC, 8'd0);
        drain_grants();

        for (int p = 0; p < PHASES; p++) begin
            mode    = $urandom_range(0, 2);
            no_idle = ($urandom_range(0, 3) == 0);
            case (mode)
                0:       begin alloc_lim = 70; claim_lim = 78; end
                1:       begin alloc_lim = 30; claim_lim = 40; end
                default: begin alloc_lim = 45; claim_lim = 60; end
            endcase
            for (int k = 0; k < PHASE_LEN; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < alloc_lim) begin
                    act = ACT_ALLOC;
                end else if (roll < claim_lim) begin
                    act = ACT_CLAIM;
                end else if (roll < 97) begin
                    act = ACT_RELEASE;
                end else begin
                    act = ACT_UNUSED;
                end
                send_request(act, pick_id(), no_idle ? 0 : $urandom_range(0, 14));
            end
            if ($urandom_range(0, 1) == 1) begin
                drain_grants();
            end
        end

        drain_grants();
        repeat (8) @(posedge i_clk);
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
